FILE: hdl/mva_pkg.sv
// Package for the matrix-vector accumulate block.
// Holds the lane control struct and the fixed widths and constants.
// Used by mva_lane and the top level under hdl, and by the testbench.
package mva_pkg;

  localparam int ROW_FIELDS = 8;
  localparam int VALUE_W    = 32;
  localparam int SUM_W      = 64;
  localparam int COUNT_W    = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic step;
    logic clear;
    logic active;
  } lane_ctrl_t;

endpackage

FILE: hdl/mva_if.sv
// Channel interfaces for the matrix-vector accumulate block.
// mva_row_if carries one matrix row word, mva_result_if one result word.
// Depends on nothing.
interface mva_row_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight;
  logic signed [31:0] row_value_0;
  logic signed [31:0] row_value_1;
  logic signed [31:0] row_value_2;
  logic signed [31:0] row_value_3;
  logic signed [31:0] row_value_4;
  logic signed [31:0] row_value_5;
  logic signed [31:0] row_value_6;
  logic signed [31:0] row_value_7;
  logic               last_row;

  modport source (
    output valid, weight, row_value_0, row_value_1, row_value_2, row_value_3,
           row_value_4, row_value_5, row_value_6, row_value_7, last_row,
    input  ready
  );
  modport sink (
    input  valid, weight, row_value_0, row_value_1, row_value_2, row_value_3,
           row_value_4, row_value_5, row_value_6, row_value_7, last_row,
    output ready
  );
endinterface

interface mva_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] sum_0;
  logic signed [63:0] sum_1;
  logic signed [63:0] sum_2;
  logic signed [63:0] sum_3;
  logic signed [63:0] sum_4;
  logic signed [63:0] sum_5;
  logic signed [63:0] sum_6;
  logic signed [63:0] sum_7;
  logic               saturated;

  modport source (
    output valid, sum_0, sum_1, sum_2, sum_3, sum_4, sum_5, sum_6, sum_7,
           saturated,
    input  ready
  );
  modport sink (
    input  valid, sum_0, sum_1, sum_2, sum_3, sum_4, sum_5, sum_6, sum_7,
           saturated,
    output ready
  );
endinterface

FILE: hdl/mva_lane.sv
// One column lane: registered 32x32 product, then saturating 64-bit accumulate.
// Depends on mva_pkg for lane_ctrl_t and the sum bounds.
module mva_lane
  import mva_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  lane_ctrl_t               ctrl,
  input  logic signed [VALUE_W-1:0] weight,
  input  logic signed [VALUE_W-1:0] value,
  output logic signed [SUM_W-1:0]  sum_next,
  output logic                     ovf
);

  logic signed [SUM_W-1:0] product;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] raw;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      product <= SUM_W'(weight * value);
    end
  end

  assign raw      = sum + product;
  assign ovf      = (sum[SUM_W-1] == product[SUM_W-1]) && (raw[SUM_W-1] != sum[SUM_W-1]);
  assign sum_next = ovf ? (sum[SUM_W-1] ? SUM_MIN : SUM_MAX) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.step) begin
      if (ctrl.clear) begin
        sum <= '0;
      end else if (ctrl.active) begin
        sum <= sum_next;
      end
    end
  end

endmodule

FILE: hdl/matrix_vector_accumulate.sv
// Top level of the matrix-vector accumulate block: lanes plus merge and result register.
// Depends on mva_pkg, mva_if (mva_row_if, mva_result_if) and mva_lane.
//
//   channel   dir  word                               handshake
//   row       in   weight, row_value_0..7, last_row   valid/ready
//   result    out  sum_0..7, saturated                valid/ready
//   config    in   active_columns (4 bits)            config_write
//
// One row per cycle while the row side is not stalled; a row passes a product stage
// and an accumulate stage, and the last row of a run loads the result register.
// Reset clears the sums, the overflow flag and the column count to eight.
// The row side stalls only when a last row reaches the accumulate stage while
// the result register still holds an untaken result.
module matrix_vector_accumulate
  import mva_pkg::*;
#(
  parameter int MAX_COLUMNS = 8
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               config_write,
  input  logic [COUNT_W-1:0] config_data,
  mva_row_if.sink            row,
  mva_result_if.source       result
);

  logic [COUNT_W-1:0]        active_columns;
  logic                      p_valid;
  logic                      p_last;
  logic                      overflow_seen;
  logic                      advance;
  logic                      accept;
  logic                      out_free;
  logic                      ovf_any;
  logic [ROW_FIELDS-1:0]     active_mask;
  logic [ROW_FIELDS-1:0]     lane_ovf;
  logic signed [VALUE_W-1:0] row_values [ROW_FIELDS];
  logic signed [SUM_W-1:0]   lane_sums  [ROW_FIELDS];
  logic signed [SUM_W-1:0]   out_sums   [ROW_FIELDS];
  lane_ctrl_t                ctrl       [ROW_FIELDS];

  assign row_values[0] = row.row_value_0;
  assign row_values[1] = row.row_value_1;
  assign row_values[2] = row.row_value_2;
  assign row_values[3] = row.row_value_3;
  assign row_values[4] = row.row_value_4;
  assign row_values[5] = row.row_value_5;
  assign row_values[6] = row.row_value_6;
  assign row_values[7] = row.row_value_7;

  assign out_free  = !result.valid || result.ready;
  assign advance   = !p_valid || !p_last || out_free;
  assign row.ready = advance;
  assign accept    = row.valid && row.ready;

  genvar c;
  generate
    for (c = 0; c < ROW_FIELDS; c++) begin : g_lane
      if (c < MAX_COLUMNS) begin : g_on
        assign active_mask[c] = (COUNT_W'(c) < active_columns);
        assign ctrl[c] = '{load:   accept,
                           step:   p_valid && advance,
                           clear:  p_last,
                           active: active_mask[c]};
        mva_lane u_lane (
          .clk      (clk),
          .rst      (rst),
          .ctrl     (ctrl[c]),
          .weight   (row.weight),
          .value    (row_values[c]),
          .sum_next (lane_sums[c]),
          .ovf      (lane_ovf[c])
        );
      end else begin : g_off
        assign active_mask[c] = 1'b0;
        assign ctrl[c]        = '0;
        assign lane_sums[c]   = '0;
        assign lane_ovf[c]    = 1'b0;
      end
    end
  endgenerate

  assign ovf_any = |(lane_ovf & active_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_columns <= COUNT_RESET;
    end else if (config_write) begin
      active_columns <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid       <= 1'b0;
      p_last        <= 1'b0;
      overflow_seen <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (p_valid && p_last && advance) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (advance) begin
        p_valid <= accept;
        p_last  <= accept && row.last_row;
      end
      if (p_valid && advance) begin
        if (p_last) begin
          overflow_seen <= 1'b0;
        end else begin
          overflow_seen <= overflow_seen | ovf_any;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && p_last && advance) begin
      for (int i = 0; i < ROW_FIELDS; i++) begin
        out_sums[i] <= active_mask[i] ? lane_sums[i] : '0;
      end
      result.saturated <= overflow_seen | ovf_any;
    end
  end

  assign result.sum_0 = out_sums[0];
  assign result.sum_1 = out_sums[1];
  assign result.sum_2 = out_sums[2];
  assign result.sum_3 = out_sums[3];
  assign result.sum_4 = out_sums[4];
  assign result.sum_5 = out_sums[5];
  assign result.sum_6 = out_sums[6];
  assign result.sum_7 = out_sums[7];

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for matrix_vector_accumulate: a directed table, then random runs of rows,
// checked word by word against an in-bench saturating accumulate predictor.
// Depends on mva_pkg, mva_if and the RTL top level.
module testbench;
  import mva_pkg::*;

  localparam int MAX_COLS     = 8;
  localparam int RANDOM_ROWS  = 1525;
  localparam int CALM_ROWS    = 150;
  localparam int DRAIN_CYCLES = 6;
  localparam int DRAIN_LIMIT  = 20000;

  localparam logic [VALUE_W-1:0] V_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] V_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] V_ONE = 32'h0001_0000;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [VALUE_W-1:0]                 weight;
    logic [ROW_FIELDS-1:0][VALUE_W-1:0] value;
    logic                               last_row;
  } row_word_t;

  typedef struct packed {
    logic [ROW_FIELDS-1:0][SUM_W-1:0] total;
    logic                             saturated;
  } result_word_t;

  typedef struct {
    bit                 is_config;
    logic [COUNT_W-1:0] count;
    row_word_t          r;
    bit                 typed;
    sum_t               tsum;
    logic               tsat;
  } step_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               config_write;
  logic [COUNT_W-1:0] config_data;

  mva_row_if    row_bus ();
  mva_result_if result_bus ();

  matrix_vector_accumulate #(.MAX_COLUMNS(MAX_COLS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_data  (config_data),
    .row          (row_bus),
    .result       (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sum_t               acc [ROW_FIELDS];
  logic               acc_overflow = 1'b0;
  logic [COUNT_W-1:0] column_count = COUNT_RESET;

  result_word_t awaited_results [$];
  step_t        directed_steps [$];
  int           mismatches = 0;
  bit           gaps_on = 1'b1;
  bit           calm = 1'b0;

  logic [ROW_FIELDS-1:0][SUM_W-1:0] seen_sums;
  assign seen_sums = {result_bus.sum_7, result_bus.sum_6, result_bus.sum_5, result_bus.sum_4,
                      result_bus.sum_3, result_bus.sum_2, result_bus.sum_1, result_bus.sum_0};

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Saturating multiply-accumulate of one row; returns 1 when the row closes a run.
  function automatic bit accumulate_row(input row_word_t r, output result_word_t res);
    sum_t                   prod;
    logic signed [SUM_W:0]  wide;
    res = '0;
    if (r.weight != '0) begin
      for (int c = 0; c < ROW_FIELDS; c++) begin
        if (c < column_count && c < MAX_COLS) begin
          prod = $signed(r.weight) * $signed(r.value[c]);
          wide = {acc[c][SUM_W-1], acc[c]} + {prod[SUM_W-1], prod};
          if (wide[SUM_W] != wide[SUM_W-1]) begin
            acc[c] = wide[SUM_W] ? SUM_MIN : SUM_MAX;
            acc_overflow = 1'b1;
          end else begin
            acc[c] = wide[SUM_W-1:0];
          end
        end
      end
    end
    if (!r.last_row) begin
      return 1'b0;
    end
    for (int c = 0; c < ROW_FIELDS; c++) begin
      res.total[c] = (c < column_count && c < MAX_COLS) ? acc[c] : '0;
      acc[c] = '0;
    end
    res.saturated = acc_overflow;
    acc_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return VALUE_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic row_word_t random_row(input bit last);
    row_word_t r;
    case ($urandom_range(0, 9))
      0:       r.weight = '0;
      1:       r.weight = V_MIN;
      2:       r.weight = V_MAX;
      3, 4:    r.weight = VALUE_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: r.weight = VALUE_W'($urandom);
    endcase
    for (int c = 0; c < ROW_FIELDS; c++) begin
      r.value[c] = random_value();
    end
    r.last_row = last;
    return r;
  endfunction

  function automatic void add_row(input logic [VALUE_W-1:0] w, input logic [VALUE_W-1:0] even,
                                  input logic [VALUE_W-1:0] odd, input logic last,
                                  input bit typed = 1'b0, input sum_t tsum = '0,
                                  input logic tsat = 1'b0);
    step_t st;
    st.is_config = 1'b0;
    st.count     = '0;
    st.r.weight  = w;
    for (int c = 0; c < ROW_FIELDS; c++) begin
      st.r.value[c] = (c % 2 == 0) ? even : odd;
    end
    st.r.last_row = last;
    st.typed      = typed;
    st.tsum       = tsum;
    st.tsat       = tsat;
    directed_steps.push_back(st);
  endfunction

  function automatic void add_count(input logic [COUNT_W-1:0] n);
    step_t st;
    st = '{is_config: 1'b1, count: n, r: '0, typed: 1'b0, tsum: '0, tsat: 1'b0};
    directed_steps.push_back(st);
  endfunction

  task automatic send_row(input row_word_t r, input bit typed, input sum_t tsum,
                          input logic tsat);
    result_word_t res;
    bit           emitted;
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      row_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    row_bus.valid       <= 1'b1;
    row_bus.weight      <= r.weight;
    row_bus.row_value_0 <= r.value[0];
    row_bus.row_value_1 <= r.value[1];
    row_bus.row_value_2 <= r.value[2];
    row_bus.row_value_3 <= r.value[3];
    row_bus.row_value_4 <= r.value[4];
    row_bus.row_value_5 <= r.value[5];
    row_bus.row_value_6 <= r.value[6];
    row_bus.row_value_7 <= r.value[7];
    row_bus.last_row    <= r.last_row;
    @(posedge clk);
    while (!row_bus.ready) @(posedge clk);
    emitted = accumulate_row(r, res);
    if (emitted) begin
      if (typed) begin
        res.total     = {ROW_FIELDS{tsum}};
        res.saturated = tsat;
      end
      awaited_results.push_back(res);
    end
  endtask

  // Drain the pipeline, then write the column count.
  task automatic write_count(input logic [COUNT_W-1:0] n);
    row_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    config_write <= 1'b1;
    config_data  <= n;
    @(posedge clk);
    config_write <= 1'b0;
    column_count = n;
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        want = awaited_results.pop_front();
        for (int c = 0; c < ROW_FIELDS; c++) begin
          if (seen_sums[c] !== want.total[c]) begin
            flag_mismatch($sformatf("sum_%0d got %h expected %h", c, seen_sums[c],
                                    want.total[c]));
          end
        end
        if (result_bus.saturated !== want.saturated) begin
          flag_mismatch($sformatf("saturated got %b expected %b", result_bus.saturated,
                                  want.saturated));
        end
      end
    end
  end

  initial begin
    result_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 32)) @(posedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("testbench failed");
    $finish;
  end

  initial begin
    int    sent;
    int    run_len;
    int    guard;
    step_t st;
    rst                 = 1'b1;
    config_write        = 1'b0;
    config_data         = '0;
    row_bus.valid       = 1'b0;
    row_bus.weight      = '0;
    row_bus.row_value_0 = '0;
    row_bus.row_value_1 = '0;
    row_bus.row_value_2 = '0;
    row_bus.row_value_3 = '0;
    row_bus.row_value_4 = '0;
    row_bus.row_value_5 = '0;
    row_bus.row_value_6 = '0;
    row_bus.row_value_7 = '0;
    row_bus.last_row    = 1'b0;
    for (int c = 0; c < ROW_FIELDS; c++) begin
      acc[c] = '0;
    end

    add_row('0, V_MAX, V_MAX, 1'b1, 1'b1, '0, 1'b0);
    add_row(V_ONE, 32'h0003_8000, 32'hFFFE_4000, 1'b0);
    add_row(32'hFFFF_0000, V_ONE, 32'h1234_5678, 1'b1);
    add_row(V_MIN, V_MIN, V_MIN, 1'b0);
    add_row(V_MIN, V_MIN, V_MIN, 1'b1, 1'b1, SUM_MAX, 1'b1);
    add_row(V_MIN, V_MAX, V_MAX, 1'b0);
    add_row(V_MIN, V_MAX, V_MAX, 1'b0);
    add_row(V_MIN, V_MAX, V_MAX, 1'b1, 1'b1, SUM_MIN, 1'b1);
    add_row(V_MAX, V_MAX, V_MAX, 1'b0);
    add_row(V_MIN, V_MIN, V_MIN, 1'b0);
    add_row(V_MIN, V_MIN, V_MIN, 1'b0);
    add_row(32'h0000_0001, V_MIN, V_MAX, 1'b1);
    add_row(V_MIN, V_MIN, V_MIN, 1'b0);
    add_row(V_MIN, V_MIN, V_MIN, 1'b0);
    add_count(4'd0);
    add_row(V_MIN, V_MIN, V_MIN, 1'b1, 1'b1, '0, 1'b1);
    add_row(V_MAX, V_MIN, V_MAX, 1'b1, 1'b1, '0, 1'b0);
    add_count(4'd1);
    add_row(V_MAX, 32'hDEAD_BEEF, 32'h7FFF_0001, 1'b1);
    add_count(4'd15);
    add_row(32'h0002_8000, V_MAX, V_MIN, 1'b0);
    add_count(4'd3);
    add_row(V_ONE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    add_count(4'd8);
    add_row(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.is_config) begin
        write_count(st.count);
      end else begin
        send_row(st.r, st.typed, st.tsum, st.tsat);
      end
    end

    sent = 0;
    while (sent < RANDOM_ROWS) begin
      calm    = (sent >= RANDOM_ROWS - CALM_ROWS);
      gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 5) == 0) begin
        write_count($urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 15))
                                         : COUNT_W'($urandom_range(1, 8)));
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < run_len; k++) begin
        if (k != 0 && $urandom_range(0, 29) == 0) begin
          write_count(COUNT_W'($urandom_range(0, 15)));
        end
        send_row(random_row(k == run_len - 1), 1'b0, '0, 1'b0);
        sent++;
      end
    end

    row_bus.valid <= 1'b0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      flag_mismatch($sformatf("%0d result words never arrived", awaited_results.size()));
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mva_pkg.sv
hdl/mva_if.sv
hdl/mva_lane.sv
hdl/matrix_vector_accumulate.sv
bench/testbench.sv
